// ----- src/speq_pkg.sv -----
package speq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH     = 256;
  localparam int PRIORITY_LEVELS = 4;
  localparam int PAYLOAD_BITS    = 32;

  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL_W  = $clog2(PRIORITY_LEVELS);

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int TYPE_W   = 8;
  localparam int PRIO_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int STAMP_W  = 64;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored queue entry
  typedef struct packed {
    logic [TYPE_W-1:0]       etype;
    logic [LEVEL_W-1:0]      level;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [STAMP_W-1:0]      stamp;
  } entry_t;

endpackage

// ----- src/stable_priority_event_queue_top.sv -----
// Stable priority event queue, up to QUEUE_DEPTH entries in PRIORITY_LEVELS levels.
// Command channel: an item is taken at a rising edge with start_i high and busy_o low.
//   command_i selects push, pop or clear; the event fields go with a push.
// Result channel: done_o is high for exactly one cycle with status_o, the popped
//   entry fields (zero unless a pop found an entry) and entry_count_o.
// Timing: the accepting edge enters the execute state, and the edge that ends
//   it registers the result and raises done_o. A new item is not taken until
//   the last one has executed: busy_o is high in the cycle after an accept,
//   while the entry memory and link memory read data is used and the link/entry
//   write-back is done. Each level is a linked FIFO in link memory; a command
//   reads one link, and a successful pop or push to a nonempty level writes one.
// The next item may be accepted in the same cycle its predecessor's result is
//   shown, since results sit in an output register.
// Pushes are FIFO within a level; pop serves the highest nonempty level.
// Reset empties all levels and marks every slot free; memory contents are not
//   cleared and need no clearing pass. The receiver cannot stall: each result is
//   presented once and taken at the end of that cycle.
module stable_priority_event_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [speq_pkg::CMD_W-1:0]    command_i,
  input  logic [speq_pkg::TYPE_W-1:0]   event_type_i,
  input  logic [speq_pkg::PRIO_W-1:0]   event_priority_i,
  input  logic [speq_pkg::HANDLE_W-1:0] payload_handle_i,
  input  logic [speq_pkg::STAMP_W-1:0]  time_stamp_i,
  output logic                          done_o,
  output logic [speq_pkg::STATUS_W-1:0] status_o,
  output logic [speq_pkg::TYPE_W-1:0]   out_type_o,
  output logic [speq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [speq_pkg::HANDLE_W-1:0] out_payload_o,
  output logic [speq_pkg::STAMP_W-1:0]  out_stamp_o,
  output logic [speq_pkg::COUNT_W-1:0]  entry_count_o
);
  import speq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Control state
  logic [SLOT_W-1:0]  head_q [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]  tail_q [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] nonempty_q;
  logic [COUNT_W-1:0] free_ptr_q, held_q;
  logic [SLOT_W-1:0]  recycle_q;

  // Latched command
  cmd_e               cmd_q;
  logic [LEVEL_W-1:0] lvl_q;
  entry_t             new_q;

  // Memories
  entry_t             entry_mem [QUEUE_DEPTH];
  logic [SLOT_W-1:0]  link_mem  [QUEUE_DEPTH];
  entry_t             entry_rd_q;
  logic [SLOT_W-1:0]  link_rd_q;

  // Result register
  logic               done_q;
  status_e            res_status_q;
  entry_t             res_entry_q;
  logic [COUNT_W-1:0] res_count_q;

  logic               accept;
  logic [LEVEL_W-1:0] top_lvl, push_lvl;
  logic               any_held;
  logic [SLOT_W-1:0]  link_rd_addr;

  assign busy_o = (state_q == S_EXEC);
  assign accept = start_i && !busy_o;

  // Highest nonempty level
  always_comb begin
    top_lvl  = '0;
    any_held = 1'b0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (nonempty_q[i]) begin
        top_lvl  = LEVEL_W'(i);
        any_held = 1'b1;
      end
    end
  end

  // Saturate incoming priority to the top level
  always_comb begin
    if (32'(event_priority_i) >= PRIORITY_LEVELS) begin
      push_lvl = LEVEL_W'(PRIORITY_LEVELS - 1);
    end else begin
      push_lvl = LEVEL_W'(event_priority_i);
    end
  end

  // Push reads the recycle stack link, pop reads the head link
  assign link_rd_addr = (cmd_e'(command_i) == CMD_PUSH) ? recycle_q : head_q[top_lvl];

  // Latch command fields at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q           <= cmd_e'(command_i);
      lvl_q           <= push_lvl;
      new_q.etype     <= event_type_i;
      new_q.level     <= push_lvl;
      new_q.payload   <= PAYLOAD_BITS'(payload_handle_i);
      new_q.stamp     <= time_stamp_i;
    end
  end

  // Execute-cycle decode
  logic               full, fresh;
  logic [SLOT_W-1:0]  push_slot, pop_slot;
  logic               entry_we, link_we;
  logic [SLOT_W-1:0]  link_wa, link_wd;

  assign full      = (held_q == COUNT_W'(QUEUE_DEPTH));
  assign fresh     = (free_ptr_q < COUNT_W'(QUEUE_DEPTH));
  assign push_slot = fresh ? free_ptr_q[SLOT_W-1:0] : recycle_q;
  assign pop_slot  = head_q[top_lvl];

  always_comb begin
    entry_we = 1'b0;
    link_we  = 1'b0;
    link_wa  = pop_slot;
    link_wd  = recycle_q;
    if (state_q == S_EXEC) begin
      case (cmd_q)
        CMD_PUSH: begin
          if (!full) begin
            entry_we = 1'b1;
            link_we  = nonempty_q[lvl_q];
            link_wa  = tail_q[lvl_q];
            link_wd  = push_slot;
          end
        end
        CMD_POP: begin
          link_we = any_held;
        end
        default: ;
      endcase
    end
  end

  // Memories: one write and one registered read a cycle each
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[push_slot] <= new_q;
    end
    if (accept) begin
      entry_rd_q <= entry_mem[head_q[top_lvl]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (accept) begin
      link_rd_q <= link_mem[link_rd_addr];
    end
  end

  // Queue control update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      nonempty_q <= '0;
      free_ptr_q <= '0;
      held_q     <= '0;
      recycle_q  <= '0;
    end else if (state_q == S_EXEC) begin
      case (cmd_q)
        CMD_PUSH: begin
          if (!full) begin
            if (fresh) begin
              free_ptr_q <= free_ptr_q + COUNT_W'(1);
            end else begin
              recycle_q <= link_rd_q;
            end
            if (!nonempty_q[lvl_q]) begin
              head_q[lvl_q] <= push_slot;
            end
            tail_q[lvl_q]     <= push_slot;
            nonempty_q[lvl_q] <= 1'b1;
            held_q            <= held_q + COUNT_W'(1);
          end
        end
        CMD_POP: begin
          if (any_held) begin
            if (tail_q[top_lvl] == pop_slot) begin
              nonempty_q[top_lvl] <= 1'b0;
            end else begin
              head_q[top_lvl] <= link_rd_q;
            end
            recycle_q <= pop_slot;
            held_q    <= held_q - COUNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            head_q[i] <= '0;
            tail_q[i] <= '0;
          end
          nonempty_q <= '0;
          free_ptr_q <= '0;
          held_q     <= '0;
          recycle_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result payload
  status_e            res_status_d;
  entry_t             res_entry_d;
  logic [COUNT_W-1:0] res_count_d;

  always_comb begin
    res_status_d = ST_OK;
    res_entry_d  = '0;
    res_count_d  = held_q;
    case (cmd_q)
      CMD_PUSH: begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          res_count_d = held_q + COUNT_W'(1);
        end
      end
      CMD_POP: begin
        if (any_held) begin
          res_entry_d = entry_rd_q;
          res_count_d = held_q - COUNT_W'(1);
        end else begin
          res_status_d = ST_EMPTY;
        end
      end
      CMD_CLEAR: begin
        res_count_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
      res_count_q  <= res_count_d;
    end
  end

  // Sequencer and result strobe
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  assign done_o         = done_q;
  assign status_o       = res_status_q;
  assign out_type_o     = res_entry_q.etype;
  assign out_priority_o = PRIO_W'(res_entry_q.level);
  assign out_payload_o  = HANDLE_W'(res_entry_q.payload);
  assign out_stamp_o    = res_entry_q.stamp;
  assign entry_count_o  = res_count_q;

`ifndef SYNTH
  // Every accepted item gets a result strobe after its execute state
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result strobe missing after accept");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // Held entries never exceed the slots handed out
  a_held_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= free_ptr_q)
    else $error("held count exceeds used slots");

  // A nonempty level set means entries are held, and vice versa
  a_levels_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q == '0) == (held_q == '0))
    else $error("level flags disagree with held count");

  // Empty status only when the queue is really empty
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_status_q == ST_EMPTY) |-> (held_q == '0) && (res_count_q == '0))
    else $error("empty status with entries held");
`endif

endmodule
